// ===== sv/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// Holds the operator and status codes, the phase codes of the serial
// datapath, and the control bundle that the sequencer hands to it.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int RESULT_WIDTH        = 32;
    localparam int IN_TDATA_WIDTH      = 8;
    localparam int OUT_TDATA_WIDTH     = 40;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } iee_op_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DIV0 = 2'd1,
        ERR_OVF  = 2'd2
    } iee_err_t;

    typedef enum logic [2:0] {
        PH_HOLD   = 3'd0,
        PH_DIGIT  = 3'd1,
        PH_ADDSUB = 3'd2,
        PH_BASE   = 3'd3,
        PH_ITER   = 3'd4,
        PH_MERGE  = 3'd5,
        PH_CLEAR  = 3'd6
    } iee_phase_t;

    typedef struct packed {
        iee_phase_t  phase;
        logic        first_bit;
        logic        last_bit;
        iee_op_t     op;
        logic [3:0]  digit;
    } iee_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/iee_datapath.sv =====
// ----------------------------------------------------------------------------
// iee_datapath: serial arithmetic of the infix expression evaluator
// Running total, last additive term and pending number live in shift
// registers that rotate one bit per cycle, least significant bit first.
// Multiply and divide take one multiplier or quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_datapath #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  iee_pkg::iee_ctrl_t       ctrl,
    output logic [VALUE_WIDTH-1:0]   total,
    output iee_pkg::iee_err_t        err_code
);
    import iee_pkg::*;

    localparam int W = VALUE_WIDTH;

    logic [W-1:0] total_reg, total_next;
    logic [W-1:0] last_reg, last_next;
    logic [W-1:0] pend_reg, pend_next;
    logic [W-1:0] acc_reg, acc_next;
    logic         carry_reg, carry_next;
    logic         aux_reg, aux_next;
    logic         seen_b_reg, seen_b_next;
    logic [1:0]   dcarry_reg, dcarry_next;
    logic [2:0]   hist_reg, hist_next;
    logic [3:0]   dsh_reg, dsh_next;
    logic         sa_reg, sa_next;
    logic         sb_reg, sb_next;
    logic         zero_reg, zero_next;
    iee_err_t     err_reg, err_next;

    // Serial adder on the running total.
    logic         add_b, add_sub, add_cinit;
    logic         cin, aux_in, seen_b;
    logic         b_eff, sum_bit, sum_cout, add_ovf;
    logic         sa, sb, neg;
    logic         src_bit, t_bit;
    logic [2:0]   h_eff;
    logic [1:0]   dc_eff;
    logic         d_bit;
    logic [2:0]   dsum;
    logic [W:0]   mul_sum;
    logic [W-1:0] rem_sh, div_diff;
    logic         div_ge;
    logic         raise_ovf, raise_div0;

    assign sa     = ctrl.first_bit ? last_reg[W-1] : sa_reg;
    assign sb     = ctrl.first_bit ? pend_reg[W-1] : sb_reg;
    assign neg    = sa_reg ^ sb_reg;
    assign seen_b = ctrl.first_bit ? 1'b0 : seen_b_reg;
    assign aux_in = ctrl.first_bit ? (ctrl.phase == PH_ADDSUB) : aux_reg;

    // The product or quotient magnitude is negated on the fly as it leaves.
    always_comb
    begin
        if (ctrl.op == OP_TIMES)
        begin
            src_bit = pend_reg[0];
        end
        else
        begin
            src_bit = zero_reg ? 1'b0 : last_reg[0];
        end
        t_bit = (neg && aux_in) ? ~src_bit : src_bit;
    end

    always_comb
    begin
        add_b     = 1'b0;
        add_sub   = 1'b0;
        add_cinit = 1'b0;
        unique case (ctrl.phase)
            PH_ADDSUB:
            begin
                add_b     = pend_reg[0];
                add_sub   = (ctrl.op == OP_MINUS);
                add_cinit = (ctrl.op == OP_MINUS);
            end
            PH_BASE:
            begin
                add_b     = last_reg[0];
                add_sub   = 1'b1;
                add_cinit = 1'b1;
            end
            PH_MERGE:
            begin
                add_b = t_bit;
            end
            default:
            begin
                add_b = 1'b0;
            end
        endcase
    end

    assign cin      = ctrl.first_bit ? add_cinit : carry_reg;
    assign b_eff    = add_b ^ add_sub;
    assign sum_bit  = total_reg[0] ^ b_eff ^ cin;
    assign sum_cout = (total_reg[0] & b_eff) | (total_reg[0] & cin) | (b_eff & cin);
    assign add_ovf  = (total_reg[0] == b_eff) && (sum_bit != total_reg[0]);

    // Digit accumulation: new = 8p + 2p + d, one bit per cycle.
    assign h_eff  = ctrl.first_bit ? 3'b000 : hist_reg;
    assign dc_eff = ctrl.first_bit ? 2'b00 : dcarry_reg;
    assign d_bit  = ctrl.first_bit ? ctrl.digit[0] : dsh_reg[0];
    assign dsum   = 3'(h_eff[2]) + 3'(h_eff[0]) + 3'(d_bit) + 3'(dc_eff);

    assign mul_sum  = {1'b0, acc_reg} + (pend_reg[0] ? {1'b0, last_reg} : '0);
    assign rem_sh   = {acc_reg[W-2:0], last_reg[W-1]};
    assign div_ge   = (rem_sh >= pend_reg);
    assign div_diff = rem_sh - pend_reg;

    always_comb
    begin
        total_next  = total_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        carry_next  = carry_reg;
        aux_next    = aux_reg;
        seen_b_next = seen_b_reg;
        dcarry_next = dcarry_reg;
        hist_next   = hist_reg;
        dsh_next    = dsh_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        zero_next   = zero_reg;
        err_next    = err_reg;
        raise_ovf   = 1'b0;
        raise_div0  = 1'b0;

        unique case (ctrl.phase)
            PH_DIGIT:
            begin
                pend_next   = {dsum[0], pend_reg[W-1:1]};
                hist_next   = {h_eff[1:0], pend_reg[0]};
                dcarry_next = dsum[2:1];
                dsh_next    = ctrl.first_bit ? {1'b0, ctrl.digit[3:1]} : {1'b0, dsh_reg[3:1]};
                // Bits pushed past the top, or a set sign bit, mean the number is too big.
                if (ctrl.last_bit)
                begin
                    raise_ovf = dsum[0] | (dsum[2:1] != 2'b00) | pend_reg[0]
                              | h_eff[0] | h_eff[1];
                end
            end
            PH_ADDSUB:
            begin
                total_next = {sum_bit, total_reg[W-1:1]};
                carry_next = sum_cout;
                if (ctrl.op == OP_MINUS)
                begin
                    last_next = {~pend_reg[0] ^ aux_in, last_reg[W-1:1]};
                end
                else
                begin
                    last_next = {pend_reg[0], last_reg[W-1:1]};
                end
                aux_next  = ~pend_reg[0] & aux_in;
                pend_next = {1'b0, pend_reg[W-1:1]};
                if (ctrl.last_bit)
                begin
                    // Negating the most negative number is the only way the term overflows.
                    raise_ovf = add_ovf | ((ctrl.op == OP_MINUS) && pend_reg[0]
                              && (~pend_reg[0] ^ aux_in));
                end
            end
            PH_BASE:
            begin
                total_next  = {sum_bit, total_reg[W-1:1]};
                carry_next  = sum_cout;
                last_next   = {(sa && aux_in) ? ~last_reg[0] : last_reg[0], last_reg[W-1:1]};
                aux_next    = aux_in | last_reg[0];
                pend_next   = {(sb && seen_b) ? ~pend_reg[0] : pend_reg[0], pend_reg[W-1:1]};
                seen_b_next = seen_b | pend_reg[0];
                sa_next     = sa;
                sb_next     = sb;
                acc_next    = '0;
                if (ctrl.first_bit)
                begin
                    zero_next = (pend_reg == '0);
                end
                if (ctrl.last_bit)
                begin
                    raise_ovf = add_ovf;
                end
            end
            PH_ITER:
            begin
                if (ctrl.op == OP_TIMES)
                begin
                    acc_next  = mul_sum[W:1];
                    pend_next = {mul_sum[0], pend_reg[W-1:1]};
                    if (ctrl.last_bit)
                    begin
                        raise_ovf = (mul_sum[W:1] != '0)
                                  || (mul_sum[0] && (!neg || (pend_reg[W-1:1] != '0)));
                    end
                end
                else if (zero_reg)
                begin
                    raise_div0 = ctrl.first_bit;
                end
                else
                begin
                    acc_next  = div_ge ? div_diff : rem_sh;
                    last_next = {last_reg[W-2:0], div_ge};
                    if (ctrl.last_bit)
                    begin
                        raise_ovf = !neg && last_reg[W-2];
                    end
                end
            end
            PH_MERGE:
            begin
                total_next = {sum_bit, total_reg[W-1:1]};
                carry_next = sum_cout;
                last_next  = {t_bit, last_reg[W-1:1]};
                aux_next   = aux_in | src_bit;
                pend_next  = {1'b0, pend_reg[W-1:1]};
                if (ctrl.last_bit)
                begin
                    raise_ovf = add_ovf;
                end
            end
            PH_CLEAR:
            begin
                total_next = '0;
                last_next  = '0;
                pend_next  = '0;
            end
            default:
            begin
                total_next = total_reg;
            end
        endcase

        // The first error of an expression is the one that is kept.
        if (ctrl.phase == PH_CLEAR)
        begin
            err_next = ERR_NONE;
        end
        else if (err_reg == ERR_NONE)
        begin
            if (raise_ovf)
            begin
                err_next = ERR_OVF;
            end
            else if (raise_div0)
            begin
                err_next = ERR_DIV0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            last_reg   <= '0;
            pend_reg   <= '0;
            err_reg    <= ERR_NONE;
        end
        else
        begin
            total_reg  <= total_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        carry_reg  <= carry_next;
        aux_reg    <= aux_next;
        seen_b_reg <= seen_b_next;
        dcarry_reg <= dcarry_next;
        hist_reg   <= hist_next;
        dsh_reg    <= dsh_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        zero_reg   <= zero_next;
    end

    assign total    = total_reg;
    assign err_code = err_reg;

endmodule

`default_nettype wire

// ===== sv/infix_expression_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top: character stream expression evaluator
// Evaluates unsigned decimal numbers joined by + - * / with the usual
// precedence and returns the value and a status on the last character.
//
// Channel  Dir  Transfer when        Contents
// s_*      in   s_tvalid & s_tready  tdata[7:0] char_code, tlast last_char
// m_*      out  m_tvalid & m_tready  tdata[31:0] value, [33:32] status
//
// A character is taken only in S_IDLE, also while a number is still pending.
// A digit is shifted into the pending number by the serial accumulator.
// Applying a number under + or - is a serial add or subtract; under * or /
// it runs serial passes for subtract, shift-add or restoring divide, and merge.
// On the last character the result register is loaded from S_EMIT; the block
// waits there while an earlier result has not been taken. Reset clears the
// control registers and the total, term, number and error registers asynchronously.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator_top #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [iee_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,   // [7:0] char_code
    input  wire                                 s_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [31:0] value, [33:32] status, rest zero
    output logic [iee_pkg::OUT_TDATA_WIDTH-1:0] m_tdata
);
    import iee_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_ADDSUB,
        S_BASE,
        S_ITER,
        S_MERGE,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    iee_op_t           op_reg, op_next;
    iee_op_t           newop_reg, newop_next;
    logic              has_op_reg, has_op_next;
    logic              active_reg, active_next;
    logic              lastc_reg, lastc_next;
    logic [3:0]        digit_reg, digit_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [RESULT_WIDTH-1:0] value_reg, value_next;
    iee_err_t          status_reg, status_next;

    iee_ctrl_t                ctrl;
    logic [VALUE_WIDTH-1:0]   total;
    iee_err_t                 err_code;
    logic [RESULT_WIDTH-1:0]  value_ext;

    logic     in_fire, out_free, is_digit, is_op, final_bit;
    iee_op_t  char_op;
    state_t   apply_state;

    iee_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .total    (total),
        .err_code (err_code)
    );

    generate
        if (VALUE_WIDTH >= RESULT_WIDTH)
        begin : g_trunc
            assign value_ext = total[RESULT_WIDTH-1:0];
        end
        else
        begin : g_sext
            assign value_ext = {{(RESULT_WIDTH-VALUE_WIDTH){total[VALUE_WIDTH-1]}}, total};
        end
    endgenerate

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign final_bit = (cnt_reg == CNT_W'(VALUE_WIDTH - 1));
    assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

    always_comb
    begin
        is_op   = 1'b1;
        char_op = OP_PLUS;
        unique case (s_tdata)
            CH_PLUS:   char_op = OP_PLUS;
            CH_MINUS:  char_op = OP_MINUS;
            CH_TIMES:  char_op = OP_TIMES;
            CH_DIVIDE: char_op = OP_DIVIDE;
            default:   is_op   = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (op_reg) inside
            OP_PLUS, OP_MINUS: apply_state = S_ADDSUB;
            default:           apply_state = S_BASE;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        newop_next    = newop_reg;
        has_op_next   = has_op_reg;
        active_next   = active_reg;
        lastc_next    = lastc_reg;
        digit_next    = digit_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        ctrl.phase     = PH_HOLD;
        ctrl.first_bit = (cnt_reg == '0);
        ctrl.last_bit  = final_bit;
        ctrl.op        = op_reg;
        ctrl.digit     = digit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    lastc_next  = s_tlast;
                    has_op_next = 1'b0;
                    cnt_next    = '0;
                    if (is_digit)
                    begin
                        digit_next = s_tdata[3:0];
                        state_next = S_DIGIT;
                    end
                    else
                    begin
                        // An operator waits until the pending number has been applied.
                        if (is_op && active_reg)
                        begin
                            has_op_next = 1'b1;
                            newop_next  = char_op;
                        end
                        else if (is_op)
                        begin
                            op_next = char_op;
                        end
                        if (active_reg)
                        begin
                            state_next = apply_state;
                        end
                        else if (s_tlast)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_DIGIT:
            begin
                ctrl.phase = PH_DIGIT;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (final_bit)
                begin
                    cnt_next    = '0;
                    active_next = 1'b1;
                    state_next  = lastc_reg ? apply_state : S_IDLE;
                end
            end
            S_ADDSUB, S_MERGE:
            begin
                ctrl.phase = (state_reg == S_ADDSUB) ? PH_ADDSUB : PH_MERGE;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (final_bit)
                begin
                    cnt_next    = '0;
                    active_next = 1'b0;
                    if (has_op_reg)
                    begin
                        op_next = newop_reg;
                    end
                    state_next = lastc_reg ? S_EMIT : S_IDLE;
                end
            end
            S_BASE:
            begin
                ctrl.phase = PH_BASE;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (final_bit)
                begin
                    cnt_next   = '0;
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                ctrl.phase = PH_ITER;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (final_bit)
                begin
                    cnt_next   = '0;
                    state_next = S_MERGE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.phase    = PH_CLEAR;
                    m_tvalid_next = 1'b1;
                    value_next    = (err_code == ERR_DIV0) ? '0 : value_ext;
                    status_next   = err_code;
                    op_next       = OP_PLUS;
                    active_next   = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            op_reg       <= OP_PLUS;
            newop_reg    <= OP_PLUS;
            has_op_reg   <= 1'b0;
            active_reg   <= 1'b0;
            lastc_reg    <= 1'b0;
            digit_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            value_reg    <= '0;
            status_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            op_reg       <= op_next;
            newop_reg    <= newop_next;
            has_op_reg   <= has_op_next;
            active_reg   <= active_next;
            lastc_reg    <= lastc_next;
            digit_reg    <= digit_next;
            m_tvalid_reg <= m_tvalid_next;
            value_reg    <= value_next;
            status_reg   <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, status_reg, value_reg};

    // A division by zero always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[33:32] == ERR_DIV0)) |-> (m_tdata[31:0] == '0))
        else $error("division by zero reported with a nonzero value");

    // The bit counter is back at zero whenever a new character can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (cnt_reg == '0))
        else $error("bit counter not at zero while idle");

    // Applying a number always consumes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MERGE) && final_bit) |=> !active_reg)
        else $error("number still pending after merge");

    // A finished result is loaded as soon as the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && !m_tvalid) |=> m_tvalid)
        else $error("result not presented although output register was free");

endmodule

`default_nettype wire
